// ===== design/bf3_pkg.sv =====
// Package for the 3x3 zero-padded box filter: widths, register map, the
// per-item control flags and the divide-by-nine reciprocal.
// No dependencies.
`default_nettype none
package bf3_pkg;

	localparam int DATA_W        = 8;
	localparam int WIDTH_W       = 11;
	localparam int HEIGHT_W      = 13;
	localparam int MAX_WIDTH_DEF = 1024;

	// APB register map, one 32-bit word per register
	localparam int APB_DATA_W = 32;
	localparam int ADDR_W     = 3;
	localparam int ADDR_IDX   = 2;
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

	// decoupling queue between classification and the filter pipeline
	localparam int QUEUE_DEPTH = 4;

	// nine pixels of 255 sum to 2295; floor(s/9) == (s*7282) >> 16 over that range
	localparam int SUM_W       = 12;
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 16;
	localparam logic [RECIP_W-1:0] RECIP_NINE = RECIP_W'(7282);

	// one window column: [0] two rows up, [1] one row up, [2] current row
	typedef logic [2:0][DATA_W-1:0] column_t;

	// what the front decides for each item
	typedef struct packed {
		logic emit;       // item completes a result
		logic first_col;  // result sits in column 0
		logic last_col;   // result sits in the last column
		logic first_row;  // result sits in row 0
		logic last_row;   // result sits in the last row
	} ctl_t;

endpackage
`default_nettype wire

// ===== design/bf3_front.sv =====
// Front end of the box filter: takes input items, tracks raster positions of
// input and result, and classifies each item for the back end.
// Depends on bf3_pkg.
`default_nettype none
module bf3_front #(
	parameter int MAX_WIDTH = bf3_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          restart,
	input  wire logic [bf3_pkg::WIDTH_W-1:0]   frame_width,
	input  wire logic [bf3_pkg::HEIGHT_W-1:0]  frame_height,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          func,
	input  wire logic [bf3_pkg::DATA_W-1:0]    pixel_in,
	input  wire logic                          q_full,
	output logic                               push,
	output logic [bf3_pkg::DATA_W-1:0]         push_pix,
	output logic [$clog2(MAX_WIDTH)-1:0]       push_col,
	output bf3_pkg::ctl_t                      push_ctl
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = bf3_pkg::HEIGHT_W;

	logic [COL_W-1:0] in_col_q;
	logic [COL_W-1:0] out_col_q;
	logic [COL_W-1:0] w_m1;
	logic [1:0]       in_row_q;   // saturates at two rows in
	logic [ROW_W-1:0] out_row_q;
	logic [ROW_W-1:0] h_m1;
	bf3_pkg::ctl_t    ctl;

	// clamp the width to 1..MAX_WIDTH and the height to at least 1
	always_comb begin
		priority if (frame_width == '0) begin
			w_m1 = '0;
		end else if (32'(frame_width) > MAX_WIDTH) begin
			w_m1 = COL_W'(MAX_WIDTH - 1);
		end else begin
			w_m1 = COL_W'(32'(frame_width) - 32'd1);
		end
	end

	assign h_m1 = (frame_height == '0) ? '0 : frame_height - ROW_W'(1);

	// a result is due once the input is one row plus one pixel ahead
	always_comb begin
		ctl.emit      = in_row_q[1] || (in_row_q == 2'd1 && in_col_q != '0);
		ctl.first_col = (out_col_q == '0);
		ctl.last_col  = (out_col_q == w_m1);
		ctl.first_row = (out_row_q == '0);
		ctl.last_row  = (out_row_q == h_m1);
	end

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;
	assign push_pix = func ? '0 : pixel_in;
	assign push_col = in_col_q;
	assign push_ctl = ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (restart) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (push) begin
			if (in_col_q == w_m1) begin
				in_col_q <= '0;
				if (!in_row_q[1]) begin
					in_row_q <= in_row_q + 2'd1;
				end
			end else begin
				in_col_q <= in_col_q + COL_W'(1);
			end
			if (ctl.emit) begin
				if (ctl.last_col) begin
					out_col_q <= '0;
					if (ctl.last_row) begin
						// frame done: start the next one from the top
						out_row_q <= '0;
						in_col_q  <= '0;
						in_row_q  <= '0;
					end else begin
						out_row_q <= out_row_q + ROW_W'(1);
					end
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/bf3_queue.sv =====
// Short first-in first-out queue that decouples the front end from the
// filter pipeline. Depends on nothing but its parameters.
`default_nettype none
module bf3_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      pop_data,
	output logic              not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     entry_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/bf3_back.sv =====
// Back end of the box filter: line store, 3x3 window, masked sum, divide by
// nine and the output register. Depends on bf3_pkg.
`default_nettype none
module bf3_back #(
	parameter int MAX_WIDTH = bf3_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_valid,
	input  wire logic [bf3_pkg::DATA_W-1:0]  q_pix,
	input  wire logic [$clog2(MAX_WIDTH)-1:0] q_col,
	input  wire bf3_pkg::ctl_t               q_ctl,
	output logic                             q_pop,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [bf3_pkg::DATA_W-1:0]       mean_out,
	output logic                             row_end,
	output logic                             frame_end
);

	localparam int DATA_W = bf3_pkg::DATA_W;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int LINE_W = 2 * DATA_W;
	localparam int SUM_W  = bf3_pkg::SUM_W;
	localparam int PROD_W = bf3_pkg::SUM_W + bf3_pkg::RECIP_W;

	// both line stores in one word: {two rows up, one row up}
	logic [LINE_W-1:0] line_mem [MAX_WIDTH];

	logic adv;

	logic                v_s1;
	logic                fwd_s1;
	logic [DATA_W-1:0]   pix_s1;
	logic [COL_W-1:0]    col_s1;
	bf3_pkg::ctl_t       ctl_s1;
	logic [LINE_W-1:0]   rd_s1;
	logic [LINE_W-1:0]   fwd_data_s1;
	logic [LINE_W-1:0]   line_s1;
	bf3_pkg::column_t    new_col_s1;
	bf3_pkg::column_t    older_q;
	bf3_pkg::column_t    newer_q;
	bf3_pkg::column_t    win_s1 [3];
	logic [SUM_W-1:0]    sum_s1;
	logic                keep;

	logic                v_s2;
	logic [SUM_W-1:0]    sum_s2;
	logic                row_end_s2;
	logic                frame_end_s2;

	logic [PROD_W-1:0]   prod;
	logic                out_valid_q;
	logic [DATA_W-1:0]   mean_q;
	logic                row_end_q;
	logic                frame_end_q;

	// the whole pipeline advances unless a result waits at the output
	assign adv   = !out_valid_q || out_ready;
	assign q_pop = adv && q_valid;

	// when the width is one, the store word is read in the cycle it is written
	assign line_s1    = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign new_col_s1 = {pix_s1, line_s1[DATA_W-1:0], line_s1[LINE_W-1:DATA_W]};

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			line_mem[col_s1] <= {new_col_s1[1], pix_s1};
		end
		if (q_pop) begin
			rd_s1 <= line_mem[q_col];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			pix_s1      <= q_pix;
			col_s1      <= q_col;
			ctl_s1      <= q_ctl;
			fwd_s1      <= v_s1 && (col_s1 == q_col);
			fwd_data_s1 <= {new_col_s1[1], pix_s1};
		end
		if (adv && v_s1) begin
			older_q <= newer_q;
			newer_q <= new_col_s1;
		end
	end

	assign win_s1[0] = older_q;
	assign win_s1[1] = newer_q;
	assign win_s1[2] = new_col_s1;

	// drop neighbours that fall outside the frame
	always_comb begin
		sum_s1 = '0;
		keep   = 1'b0;
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				keep = !((c == 0 && ctl_s1.first_col) || (c == 2 && ctl_s1.last_col) ||
					(r == 0 && ctl_s1.first_row) || (r == 2 && ctl_s1.last_row));
				if (keep) begin
					sum_s1 = sum_s1 + SUM_W'(win_s1[c][r]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			sum_s2       <= sum_s1;
			row_end_s2   <= ctl_s1.last_col;
			frame_end_s2 <= ctl_s1.last_col && ctl_s1.last_row;
		end
	end

	assign prod = PROD_W'(sum_s2) * PROD_W'(bf3_pkg::RECIP_NINE);

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			mean_q      <= prod[bf3_pkg::RECIP_SHIFT +: DATA_W];
			row_end_q   <= row_end_s2;
			frame_end_q <= frame_end_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= q_valid;
			v_s2        <= v_s1 && ctl_s1.emit;
			out_valid_q <= v_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign mean_out  = mean_q;
	assign row_end   = row_end_q;
	assign frame_end = frame_end_q;

endmodule
`default_nettype wire

// ===== design/box_filter_3x3_zero_pad.sv =====
// Streaming 3x3 box filter with a zero border: top level.
// Grey pixels enter in raster order on the input channel (func = 0 pixel,
// func = 1 drain item, which pushes a zero). Each result is the floor of the
// 3x3 neighbourhood sum divided by nine, with neighbours outside the frame
// taken as zero. The result for raster position q leaves with the item that
// takes position q + frame_width + 1, so a frame is width*height pixels
// followed by width + 1 drain items; row_end and frame_end mark the last
// result of a row and of the frame, after which a new frame starts.
// Throughput: one item per clock while the output is not stalled. An accepted
// item that completes a result passes the queue, line store read, sum, and
// multiply by nine's reciprocal into the output register behind out_valid.
// frame_width and frame_height sit at byte addresses 0 and 4 of the APB port;
// any write restarts the frame. Write them only while no item is in flight.
// Reset: counters cleared, frame 640 by 480. The line store is not cleared;
// the border masking keeps stale contents out of every result.
// Receiver stall: the output register holds its result and the pipeline
// halts; a four-entry queue keeps taking input until it fills, then in_ready
// drops. Depends on bf3_pkg, bf3_front, bf3_queue and bf3_back.
`default_nettype none
module box_filter_3x3_zero_pad #(
	parameter int MAX_WIDTH = bf3_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [bf3_pkg::ADDR_W-1:0]        paddr,
	input  wire logic [bf3_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [bf3_pkg::APB_DATA_W-1:0]         prdata,
	output logic                                   pready,
	// pixel items
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              func,
	input  wire logic [bf3_pkg::DATA_W-1:0]        pixel_in,
	// results
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [bf3_pkg::DATA_W-1:0]             mean_out,
	output logic                                   row_end,
	output logic                                   frame_end
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int QW    = bf3_pkg::DATA_W + COL_W + $bits(bf3_pkg::ctl_t);

	logic [bf3_pkg::WIDTH_W-1:0]  width_q;
	logic [bf3_pkg::HEIGHT_W-1:0] height_q;
	logic                         cfg_wr;

	logic                         push;
	logic [bf3_pkg::DATA_W-1:0]   push_pix;
	logic [COL_W-1:0]             push_col;
	bf3_pkg::ctl_t                push_ctl;
	logic                         q_full;
	logic                         q_pop;
	logic                         q_valid;
	logic [QW-1:0]                q_head;
	bf3_pkg::ctl_t                q_ctl;
	logic [COL_W-1:0]             q_col;
	logic [bf3_pkg::DATA_W-1:0]   q_pix;

	// registers take the write in the access phase; no wait states
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bf3_pkg::WIDTH_RESET;
			height_q <= bf3_pkg::HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[bf3_pkg::ADDR_IDX])
				bf3_pkg::REG_FRAME_WIDTH:  width_q  <= pwdata[bf3_pkg::WIDTH_W-1:0];
				bf3_pkg::REG_FRAME_HEIGHT: height_q <= pwdata[bf3_pkg::HEIGHT_W-1:0];
				default:                   width_q  <= width_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[bf3_pkg::ADDR_IDX])
			bf3_pkg::REG_FRAME_WIDTH:  prdata = bf3_pkg::APB_DATA_W'(width_q);
			bf3_pkg::REG_FRAME_HEIGHT: prdata = bf3_pkg::APB_DATA_W'(height_q);
			default:                   prdata = '0;
		endcase
	end

	// front: classify items and track positions; any write restarts the frame
	bf3_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.restart     (cfg_wr),
		.frame_width (width_q),
		.frame_height(height_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.pixel_in    (pixel_in),
		.q_full      (q_full),
		.push        (push),
		.push_pix    (push_pix),
		.push_col    (push_col),
		.push_ctl    (push_ctl)
	);

	// queue: lets the front keep accepting while the output is stalled
	bf3_queue #(
		.W    (QW),
		.DEPTH(bf3_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_ctl, push_col, push_pix}),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_head),
		.not_empty(q_valid)
	);

	assign {q_ctl, q_col, q_pix} = q_head;

	// back: line store, window, sum and divide
	bf3_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pix    (q_pix),
		.q_col    (q_col),
		.q_ctl    (q_ctl),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mean_out (mean_out),
		.row_end  (row_end),
		.frame_end(frame_end)
	);

endmodule
`default_nettype wire

// ===== design/bf3_checker.sv =====
// Port-level checks for the box filter, bound to the top level.
// Depends on bf3_pkg and box_filter_3x3_zero_pad.
`default_nettype none
module bf3_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           psel,
	input wire logic                           penable,
	input wire logic                           pwrite,
	input wire logic [bf3_pkg::ADDR_W-1:0]     paddr,
	input wire logic [bf3_pkg::APB_DATA_W-1:0] pwdata,
	input wire logic [bf3_pkg::APB_DATA_W-1:0] prdata,
	input wire logic                           pready,
	input wire logic                           in_valid,
	input wire logic                           in_ready,
	input wire logic                           func,
	input wire logic [bf3_pkg::DATA_W-1:0]     pixel_in,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic [bf3_pkg::DATA_W-1:0]     mean_out,
	input wire logic                           row_end,
	input wire logic                           frame_end
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mean_out) &&
		$stable(row_end) && $stable(frame_end))
		else $error("result changed while stalled");

	// a waiting input item keeps its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(func) && $stable(pixel_in))
		else $error("input item changed while waiting");

	// the last result of a frame is also the last of its row
	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> row_end)
		else $error("frame_end without row_end");

	// a width write reads back on the next cycle
	a_width_readback: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n && psel && penable && pwrite && pready &&
		paddr[bf3_pkg::ADDR_IDX] == bf3_pkg::REG_FRAME_WIDTH) &&
		paddr[bf3_pkg::ADDR_IDX] == bf3_pkg::REG_FRAME_WIDTH |->
		prdata[bf3_pkg::WIDTH_W-1:0] == $past(pwdata[bf3_pkg::WIDTH_W-1:0]))
		else $error("frame_width readback mismatch");

	// out of reset the block is empty and takes input
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> in_ready && !out_valid && pready)
		else $error("block not empty after reset");

endmodule

bind box_filter_3x3_zero_pad bf3_checker u_bf3_checker (.*);
`default_nettype wire
